// ----- rtl/core/spirxdf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spirxdf_pkg
// Shared types and constants of the serial-link receive frame deframer.
// ----------------------------------------------------------------------------
package spirxdf_pkg;

  // frame layout
  localparam int HEADER_BYTES  = 12;
  localparam int TRAILER_BYTES = 2;
  localparam logic [7:0] SYNC_BYTE = 8'hAA;

  // field widths
  localparam int BYTE_W  = 8;
  localparam int FLEN_W  = 16;
  localparam int PLEN_W  = 11;
  localparam int FILL_W  = $clog2(HEADER_BYTES);
  localparam int CFG_W   = 16;
  localparam int CADDR_W = 1;

  // configuration register indexes
  localparam logic [CADDR_W-1:0] CFG_MAX_FRAME   = 1'b0;
  localparam logic [CADDR_W-1:0] CFG_MAX_PAYLOAD = 1'b1;

  // receive phase
  typedef enum logic [1:0] {
    PH_HUNT,
    PH_PAYLOAD,
    PH_TRAILER
  } phase_t;

  // one result: payload byte with its marks
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              empty;
  } res_t;

endpackage : spirxdf_pkg
`default_nettype wire

// ----- rtl/core/spi_rx_frame_deframer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spi_rx_frame_deframer
// Hunts for a 12-byte packet header in the received byte stream and passes
// the payload bytes of each valid packet out, marking the final one.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one received byte per request (in_tdata = rx_byte).
//   out_* : payload bytes; out_tlast marks the final byte of a packet and
//           out_tuser flags the single result of a zero-length packet
//           (data zero, tlast set).
//   cfg_* : write-only limits, index 0 max frame length, 1 max payload length.
// Throughput is one byte per cycle while in_tready is high. Header check,
// payload delay and trailer skip are all done in one pass from the input
// byte and the state registers; a result goes straight into the output
// register when that is free. A payload byte is released two bytes later
// than it arrives, so the last one can be marked when the second trailer
// byte comes. When the receiver stalls, one more result is held in a skid
// register and in_tready drops only while that register is full.
// Reset (synchronous, rst_n low) restores the default limits, empties the
// header window and the output side; the block hunts for a header again.
// ----------------------------------------------------------------------------
module spi_rx_frame_deframer
  import spirxdf_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst_n,
  // configuration
  input  wire                      cfg_we,
  input  wire [CADDR_W-1:0]        cfg_addr,
  input  wire [CFG_W-1:0]          cfg_wdata,
  // received bytes
  input  wire                      in_tvalid,
  output logic                     in_tready,
  input  wire [BYTE_W-1:0]         in_tdata,   // [7:0] rx_byte
  // payload bytes
  output logic                     out_tvalid,
  input  wire                      out_tready,
  output logic [BYTE_W-1:0]        out_tdata,  // [7:0] payload_byte
  output logic                     out_tlast,
  output logic                     out_tuser   // [0] empty_res
);

  // configuration registers
  logic [FLEN_W-1:0] max_flen_r;
  logic [PLEN_W-1:0] max_plen_r;

  // deframer state
  phase_t              phase_r, phase_nxt;
  logic [BYTE_W-1:0]   win_r   [HEADER_BYTES];
  logic [BYTE_W-1:0]   win_nxt [HEADER_BYTES];
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [PLEN_W-1:0]   rem_r, rem_nxt;
  logic [BYTE_W-1:0]   dly_r   [2];
  logic [BYTE_W-1:0]   dly_nxt [2];
  logic [1:0]          dfill_r, dfill_nxt;

  // output side
  logic out_vld_r, skid_vld_r;
  res_t out_r, skid_r;

  logic in_acc, out_free, hdr_ok;
  logic res_vld;
  res_t res;
  logic [PLEN_W-1:0] hdr_plen;

  assign in_tready = !skid_vld_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_flen_r <= FLEN_W'(3163);
      max_plen_r <= PLEN_W'(1500);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MAX_FRAME:   max_flen_r <= cfg_wdata;
        CFG_MAX_PAYLOAD: max_plen_r <= cfg_wdata[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // window after shifting in the new byte
  always_comb begin
    for (int i = 0; i < HEADER_BYTES - 1; i++) begin
      win_nxt[i] = win_r[i+1];
    end
    win_nxt[HEADER_BYTES-1] = in_tdata;
  end

  // header check on the shifted window
  assign hdr_plen = {win_nxt[9][PLEN_W-1-8:0], win_nxt[8]};
  assign hdr_ok = (win_nxt[0] == '0) && (win_nxt[1] == '0) &&
                  ({win_nxt[2], win_nxt[3]} <= max_flen_r) &&
                  (win_nxt[4] == SYNC_BYTE) &&
                  ((win_nxt[4] ^ win_nxt[5] ^ win_nxt[6] ^ win_nxt[7]) == '0) &&
                  (win_nxt[10] == '0) && (win_nxt[11] == '0) &&
                  (win_nxt[9][BYTE_W-1:PLEN_W-8] == '0) &&
                  (hdr_plen <= max_plen_r);

  // next state and result for one accepted byte
  always_comb begin
    phase_nxt  = phase_r;
    fill_nxt   = fill_r;
    rem_nxt    = rem_r;
    dly_nxt[0] = dly_r[0];
    dly_nxt[1] = dly_r[1];
    dfill_nxt  = dfill_r;
    res_vld    = 1'b0;
    res.data   = dly_r[0];
    res.last   = 1'b0;
    res.empty  = 1'b0;
    unique case (phase_r)
      PH_PAYLOAD: begin
        // two-byte delay, oldest byte leaves once both are full
        if (dfill_r == 2'd0) begin
          dly_nxt[0] = in_tdata;
          dfill_nxt  = 2'd1;
        end else if (dfill_r == 2'd1) begin
          dly_nxt[1] = in_tdata;
          dfill_nxt  = 2'd2;
        end else begin
          res_vld    = 1'b1;
          dly_nxt[0] = dly_r[1];
          dly_nxt[1] = in_tdata;
        end
        rem_nxt = rem_r - PLEN_W'(1);
        if (rem_r == PLEN_W'(1)) begin
          phase_nxt = PH_TRAILER;
          rem_nxt   = PLEN_W'(TRAILER_BYTES);
        end
      end
      PH_TRAILER: begin
        if (rem_r > PLEN_W'(1)) begin
          // first trailer byte releases the older delayed byte
          rem_nxt = rem_r - PLEN_W'(1);
          if (dfill_r == 2'd2) begin
            res_vld    = 1'b1;
            dly_nxt[0] = dly_r[1];
            dfill_nxt  = 2'd1;
          end
        end else begin
          // second trailer byte closes the packet
          phase_nxt = PH_HUNT;
          rem_nxt   = '0;
          fill_nxt  = '0;
          dfill_nxt = 2'd0;
          res_vld   = 1'b1;
          res.last  = 1'b1;
          if (dfill_r == 2'd0) begin
            res.data  = '0;
            res.empty = 1'b1;
          end
        end
      end
      default: begin
        // hunting: count bytes until the window is full, then check it
        phase_nxt = PH_HUNT;
        if (fill_r != FILL_W'(HEADER_BYTES - 1)) begin
          fill_nxt = fill_r + FILL_W'(1);
        end else if (hdr_ok) begin
          fill_nxt  = '0;
          dfill_nxt = 2'd0;
          if (hdr_plen == '0) begin
            phase_nxt = PH_TRAILER;
            rem_nxt   = PLEN_W'(TRAILER_BYTES);
          end else begin
            phase_nxt = PH_PAYLOAD;
            rem_nxt   = hdr_plen;
          end
        end
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      fill_r  <= '0;
      rem_r   <= '0;
      dfill_r <= 2'd0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
      rem_r   <= rem_nxt;
      dfill_r <= dfill_nxt;
    end
  end

  // window and delay line data
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (phase_r != PH_PAYLOAD && phase_r != PH_TRAILER) begin
        for (int i = 0; i < HEADER_BYTES; i++) begin
          win_r[i] <= win_nxt[i];
        end
      end
      dly_r[0] <= dly_nxt[0];
      dly_r[1] <= dly_nxt[1];
    end
  end

  // output register and skid register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r  <= skid_vld_r || (in_acc && res_vld);
      skid_vld_r <= 1'b0;
    end else if (in_acc && res_vld) begin
      skid_vld_r <= 1'b1;
    end
  end

  // output and skid data
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_vld_r ? skid_r : res;
    end else if (in_acc && res_vld) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r.data;
  assign out_tlast  = out_r.last;
  assign out_tuser  = out_r.empty;

  // checks
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid register full while output register empty");

  a_trailer_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TRAILER) |-> (rem_r == PLEN_W'(1) || rem_r == PLEN_W'(2)))
    else $error("trailer byte count out of range");

  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (rem_r != '0))
    else $error("payload phase with no bytes left");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.empty) |-> (out_r.last && out_r.data == '0))
    else $error("empty packet result without last or with data");

  a_hunt_delay_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r == PH_TRAILER && rem_r == PLEN_W'(1)) |=>
      (phase_r == PH_HUNT && dfill_r == 2'd0 && fill_r == '0))
    else $error("packet end did not restart header hunt");

endmodule : spi_rx_frame_deframer
`default_nettype wire

// ----- bench/spi_rx_frame_deframer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_rx_frame_deframer_tb
// Self-checking bench for the receive deframer. A short table of hand-built
// packets runs first. Then come random phases under several limit settings.
// Those phases mix well-formed packets with random payload, headers with
// one fault each, and loose noise bytes. A behavioral deframer in the bench
// predicts every payload request, and each output request is compared with
// the oldest prediction. Both sides idle at random, and once the output
// side holds off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module spi_rx_frame_deframer_tb;
  import spirxdf_pkg::*;

  localparam int CYCLE_LIMIT    = 600000;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 6;
  localparam int MAX_REPORTS    = 40;

  // one deliberate header fault per broken packet
  typedef enum int {
    FLT_NONE,
    FLT_FRAME,
    FLT_SYNC,
    FLT_PARITY,
    FLT_VERSION,
    FLT_LENGTH
  } fault_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    res_t       want;
  } dir_row_t;

  localparam res_t NO_RES = '0;

  // zero-length packet, then a one-byte packet carrying 0xff
  localparam dir_row_t DIRECTED [29] = '{
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h0E, 1'b0, NO_RES}, '{SYNC_BYTE, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{SYNC_BYTE, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h55, 1'b0, NO_RES}, '{8'hFF, 1'b1, res_t'{8'h00, 1'b1, 1'b1}},
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h0F, 1'b0, NO_RES}, '{SYNC_BYTE, 1'b0, NO_RES}, '{8'h12, 1'b0, NO_RES},
    '{8'h34, 1'b0, NO_RES}, '{8'h8C, 1'b0, NO_RES}, '{8'h01, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b1, res_t'{8'hFF, 1'b1, 1'b0}}
  };

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [CADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [BYTE_W-1:0]  in_tdata  = '0;   // [7:0] rx_byte
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [BYTE_W-1:0]  out_tdata;        // [7:0] payload_byte
  logic               out_tlast;
  logic               out_tuser;        // [0] empty_res

  // deframer mirror state
  logic [7:0]  hdr_win [HEADER_BYTES];
  int unsigned hdr_fill;
  phase_t      rx_phase;
  logic [10:0] pay_left;
  logic [7:0]  delay_bytes [2];
  int unsigned delay_fill;
  logic [15:0] lim_frame;
  logic [10:0] lim_payload;

  res_t        pending_out [$];
  int unsigned errors = 0;
  int unsigned bytes_offered = 0;
  int unsigned cycle_count;
  bit          gaps_on = 1'b1;
  bit          squeeze_req = 1'b0;

  spi_rx_frame_deframer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // advance the mirror by one received byte, returns 1 when a payload
  // request comes out of it
  function automatic bit deframe(input logic [7:0] b, output res_t r);
    logic [31:0] flen;
    logic [15:0] plen;
    bit          got;
    got = 1'b0;
    r   = '0;
    case (rx_phase)
      PH_PAYLOAD: begin
        // release the byte two places back
        if (delay_fill >= 2) begin
          r              = res_t'{delay_bytes[0], 1'b0, 1'b0};
          got            = 1'b1;
          delay_bytes[0] = delay_bytes[1];
          delay_bytes[1] = '0;
          delay_fill--;
        end
        delay_bytes[delay_fill] = b;
        delay_fill++;
        pay_left = pay_left - 11'd1;
        if (pay_left == 11'd0) begin
          rx_phase = PH_TRAILER;
          pay_left = 11'(TRAILER_BYTES);
        end
      end
      PH_TRAILER: begin
        if (pay_left > 11'd1) begin
          pay_left--;
          if (delay_fill >= 2) begin
            r              = res_t'{delay_bytes[0], 1'b0, 1'b0};
            got            = 1'b1;
            delay_bytes[0] = delay_bytes[1];
            delay_bytes[1] = '0;
            delay_fill--;
          end
        end else begin
          // second trailer byte closes the packet
          got = 1'b1;
          r   = (delay_fill == 0) ? res_t'{8'h00, 1'b1, 1'b1}
                                  : res_t'{delay_bytes[0], 1'b1, 1'b0};
          rx_phase       = PH_HUNT;
          pay_left       = '0;
          hdr_fill       = 0;
          delay_fill     = 0;
          delay_bytes[0] = '0;
          delay_bytes[1] = '0;
        end
      end
      default: begin
        rx_phase = PH_HUNT;
        if (hdr_fill >= HEADER_BYTES) hdr_fill = HEADER_BYTES - 1;
        hdr_win[hdr_fill] = b;
        hdr_fill++;
        if (hdr_fill == HEADER_BYTES) begin
          flen = {hdr_win[0], hdr_win[1], hdr_win[2], hdr_win[3]};
          plen = {hdr_win[9], hdr_win[8]};
          if (flen <= {16'h0, lim_frame} && hdr_win[4] == SYNC_BYTE &&
              (hdr_win[4] ^ hdr_win[5] ^ hdr_win[6] ^ hdr_win[7]) == 8'h00 &&
              hdr_win[10] == 8'h00 && hdr_win[11] == 8'h00 &&
              plen <= {5'h0, lim_payload}) begin
            hdr_fill       = 0;
            delay_fill     = 0;
            delay_bytes[0] = '0;
            delay_bytes[1] = '0;
            if (plen == 16'h0) begin
              rx_phase = PH_TRAILER;
              pay_left = 11'(TRAILER_BYTES);
            end else begin
              rx_phase = PH_PAYLOAD;
              pay_left = plen[10:0];
            end
          end else begin
            // bad header: drop the oldest byte
            for (int i = 0; i < HEADER_BYTES - 1; i++) hdr_win[i] = hdr_win[i + 1];
            hdr_win[HEADER_BYTES - 1] = '0;
            hdr_fill = HEADER_BYTES - 1;
          end
        end
      end
    endcase
    return got;
  endfunction

  // offer one byte, wait for the request to be taken, log the prediction
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input res_t want = '0);
    res_t r;
    bit   got;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_offered++;
    got = deframe(b, r);
    if (typed) pending_out.push_back(want);
    else if (got) pending_out.push_back(r);
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n) send_byte(8'($urandom));
  endtask

  // header with at most one fault, then payload and trailer if it is good
  task automatic send_packet(input fault_t fault, input int unsigned plen);
    logic [31:0] flen;
    logic [15:0] plen_field;
    logic [15:0] ver;
    logic [7:0]  sync;
    logic [7:0]  x5;
    logic [7:0]  x6;
    logic [7:0]  x7;
    logic [7:0]  head [HEADER_BYTES];
    flen       = ($urandom_range(0, 9) == 0) ? 32'(lim_frame)
                                             : 32'($urandom_range(0, lim_frame));
    sync       = SYNC_BYTE;
    x5         = 8'($urandom);
    x6         = 8'($urandom);
    plen_field = 16'(plen);
    ver        = '0;
    case (fault)
      FLT_FRAME: begin
        if ($urandom_range(0, 1) == 0) flen = 32'(lim_frame) + 32'd1;
        else begin
          flen = $urandom;
          while (flen <= 32'(lim_frame)) flen = $urandom;
        end
      end
      FLT_SYNC: begin
        sync = 8'($urandom);
        if (sync == SYNC_BYTE) sync = ~sync;
      end
      FLT_VERSION: ver = 16'($urandom_range(1, 65535));
      FLT_LENGTH: begin
        if ($urandom_range(0, 1) == 0) plen_field = 16'(lim_payload) + 16'd1;
        else plen_field = 16'($urandom_range(lim_payload + 1, 65535));
      end
      default: ;
    endcase
    // start bytes xor to zero unless the parity fault flips one bit
    x7 = sync ^ x5 ^ x6;
    if (fault == FLT_PARITY) x7 = x7 ^ 8'(1 << $urandom_range(0, 7));
    head = '{flen[31:24], flen[23:16], flen[15:8], flen[7:0], sync, x5, x6, x7,
             plen_field[7:0], plen_field[15:8], ver[7:0], ver[15:8]};
    foreach (head[i]) send_byte(head[i]);
    if (fault == FLT_NONE) begin
      repeat (plen) send_byte(8'($urandom));
      repeat (TRAILER_BYTES) send_byte(8'($urandom));
    end else begin
      send_noise($urandom_range(0, 6));
    end
  endtask

  // random traffic under the current limits until the byte budget is spent
  task automatic run_phase(input int unsigned budget);
    int unsigned first;
    int unsigned pick;
    int unsigned cap;
    int unsigned plen;
    first = bytes_offered;
    while (bytes_offered - first < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_noise($urandom_range(1, 5));
      end else if (pick < 30) begin
        send_packet(fault_t'($urandom_range(FLT_FRAME, FLT_LENGTH)), 0);
      end else begin
        // mostly short packets, a few long ones
        pick = $urandom_range(0, 99);
        cap  = (pick < 80) ? 12 : (pick < 95) ? 64 : 400;
        if (cap > lim_payload) cap = lim_payload;
        if ($urandom_range(0, 19) == 0 && lim_payload <= 400) plen = lim_payload;
        else plen = $urandom_range(0, cap);
        send_packet(FLT_NONE, plen);
      end
    end
  endtask

  // let every predicted request drain before touching the limits
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limits(input logic [15:0] frame_max, input logic [10:0] payload_max);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_MAX_FRAME;
    cfg_wdata <= frame_max;
    @(posedge clk);
    cfg_addr  <= CFG_MAX_PAYLOAD;
    cfg_wdata <= CFG_W'(payload_max);
    @(posedge clk);
    cfg_we      <= 1'b0;
    lim_frame   = frame_max;
    lim_payload = payload_max;
  endtask

  // main sequence
  initial begin : stimulus
    hdr_win        = '{default: '0};
    hdr_fill       = 0;
    rx_phase       = PH_HUNT;
    pay_left       = '0;
    delay_bytes    = '{default: '0};
    delay_fill     = 0;
    lim_frame      = 16'd3163;
    lim_payload    = 11'd1500;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) send_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].want);
    run_phase(130);

    // widest limits, a long packet while the output side holds off
    settle();
    write_limits(16'hFFFF, 11'h7FF);
    squeeze_req = 1'b1;
    send_packet(FLT_NONE, 300);
    run_phase(120);

    // tightest limits: only empty packets with zero frame length get through
    settle();
    write_limits(16'h0000, 11'h000);
    run_phase(150);

    settle();
    write_limits(16'($urandom), 11'($urandom_range(1, 40)));
    run_phase(150);

    settle();
    write_limits(16'd14, 11'd1);
    run_phase(120);

    // closing stretch without idling
    settle();
    gaps_on = 1'b0;
    write_limits(16'($urandom), 11'($urandom));
    run_phase(180);

    settle();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // output side ready, with random holds and one long hold-off
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        out_tready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeeze_req = 1'b0;
        out_tready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // compare each taken output request with the oldest prediction
  always @(posedge clk) begin : result_check
    res_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_out.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected request data=%h last=%b empty=%b",
                   $time, out_tdata, out_tlast, out_tuser);
      end else begin
        w = pending_out.pop_front();
        if (out_tdata !== w.data || out_tlast !== w.last || out_tuser !== w.empty) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: mismatch expected data=%h last=%b empty=%b, actual data=%h last=%b empty=%b",
                     $time, w.data, w.last, w.empty, out_tdata, out_tlast, out_tuser);
        end
      end
    end
  end

  // watchdog
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule
